// ===== rtl/core/leb_pkg.sv =====
// leb_pkg: word types, key codes and the microcode table for the line edit buffer.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package leb_pkg;

    // Input word: one key byte with its plain/extended mark.
    typedef struct packed {
        logic       kind;
        logic [7:0] key_code;
    } leb_key_t;

    // Output word: one line character or the status word that closes a key.
    typedef struct packed {
        logic       item_type;
        logic [7:0] char_value;
        logic [5:0] char_index;
        logic [5:0] cursor;
        logic [5:0] line_length;
        logic       insert_on;
        logic       finished;
        logic       last;
    } leb_res_t;

    localparam logic [7:0] KEY_BACKSPACE = 8'd8;
    localparam logic [7:0] KEY_ESCAPE    = 8'd27;
    localparam logic [7:0] KEY_LEFT      = 8'd75;
    localparam logic [7:0] KEY_RIGHT     = 8'd77;
    localparam logic [7:0] KEY_INSERT    = 8'd82;
    localparam logic [7:0] KEY_DELETE    = 8'd83;
    localparam logic [7:0] PRINT_LOW     = 8'd32;
    localparam logic [7:0] PRINT_HIGH    = 8'd126;

    localparam logic ITEM_CHAR   = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;

    // Datapath actions
    localparam logic [2:0] ACT_ACCEPT = 3'd0;
    localparam logic [2:0] ACT_DECODE = 3'd1;
    localparam logic [2:0] ACT_SHIFT  = 3'd2;
    localparam logic [2:0] ACT_PUT    = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;
    localparam logic [2:0] ACT_CHAR   = 3'd5;
    localparam logic [2:0] ACT_STATUS = 3'd6;
    localparam logic [2:0] ACT_NOP    = 3'd7;

    // Jump conditions
    localparam logic [2:0] CND_NEXT       = 3'd0;
    localparam logic [2:0] CND_ALWAYS     = 3'd1;
    localparam logic [2:0] CND_NO_KEY     = 3'd2;
    localparam logic [2:0] CND_SHIFT_BUSY = 3'd3;
    localparam logic [2:0] CND_NO_REDRAW  = 3'd4;
    localparam logic [2:0] CND_MORE       = 3'd5;

    // Program steps
    localparam logic [2:0] ST_WAIT   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_SHIFT  = 3'd2;
    localparam logic [2:0] ST_PUT    = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_CHAR   = 3'd5;
    localparam logic [2:0] ST_STATUS = 3'd6;

    // One control word: action, jump condition, hold while output is blocked, target.
    typedef struct packed {
        logic [2:0] act;
        logic [2:0] cond;
        logic       hold;
        logic [2:0] target;
    } leb_ctrl_t;

    // Datapath status tested by the sequencer.
    typedef struct packed {
        logic key_live;
        logic shift_busy;
        logic no_redraw;
        logic more;
        logic out_blocked;
    } leb_flags_t;

    function automatic leb_ctrl_t ucode_word(input logic [2:0] step);
        leb_ctrl_t w;
        case (step)
            ST_WAIT:   w = '{act: ACT_ACCEPT, cond: CND_NO_KEY,     hold: 1'b0, target: ST_WAIT};
            ST_DECODE: w = '{act: ACT_DECODE, cond: CND_NEXT,       hold: 1'b0, target: ST_WAIT};
            ST_SHIFT:  w = '{act: ACT_SHIFT,  cond: CND_SHIFT_BUSY, hold: 1'b0, target: ST_SHIFT};
            ST_PUT:    w = '{act: ACT_PUT,    cond: CND_NO_REDRAW,  hold: 1'b0, target: ST_STATUS};
            ST_READ:   w = '{act: ACT_READ,   cond: CND_NEXT,       hold: 1'b0, target: ST_WAIT};
            ST_CHAR:   w = '{act: ACT_CHAR,   cond: CND_MORE,       hold: 1'b1, target: ST_READ};
            ST_STATUS: w = '{act: ACT_STATUS, cond: CND_ALWAYS,     hold: 1'b1, target: ST_WAIT};
            default:   w = '{act: ACT_NOP,    cond: CND_ALWAYS,     hold: 1'b0, target: ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/leb_seq.sv =====
// leb_seq: step counter and jump logic over the microcode table.
// Depends on leb_pkg (control word, flags, program table).
`timescale 1ns / 1ps

module leb_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  leb_pkg::leb_flags_t flags,
    output leb_pkg::leb_ctrl_t  ctrl
);

    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       cond_true;

    assign ctrl = leb_pkg::ucode_word(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            leb_pkg::CND_NEXT:       cond_true = 1'b0;
            leb_pkg::CND_ALWAYS:     cond_true = 1'b1;
            leb_pkg::CND_NO_KEY:     cond_true = !flags.key_live;
            leb_pkg::CND_SHIFT_BUSY: cond_true = flags.shift_busy;
            leb_pkg::CND_NO_REDRAW:  cond_true = flags.no_redraw;
            leb_pkg::CND_MORE:       cond_true = flags.more;
            default:                 cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (ctrl.hold && flags.out_blocked)
            step_next = step_reg;
        else if (cond_true)
            step_next = ctrl.target;
        else
            step_next = step_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= leb_pkg::ST_WAIT;
        else
            step_reg <= step_next;
    end

endmodule

// ===== rtl/core/leb_datapath.sv =====
// leb_datapath: line store, cursor/length/mode registers, shift engine and output register.
// Depends on leb_pkg; driven by the control word from leb_seq.
`timescale 1ns / 1ps

module leb_datapath
#(
    parameter int LINE_CAPACITY = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  leb_pkg::leb_ctrl_t  ctrl,
    output leb_pkg::leb_flags_t flags,
    input  logic                key_valid,
    output logic                key_stall,
    input  leb_pkg::leb_key_t   key,
    output logic                res_valid,
    input  logic                res_stall,
    output leb_pkg::leb_res_t   res
);

    localparam int PW = $clog2(LINE_CAPACITY);
    localparam logic [PW-1:0] LAST_POS = PW'(LINE_CAPACITY - 1);
    localparam logic [PW-1:0] ONE      = PW'(1);

    logic [7:0] mem [LINE_CAPACITY];
    logic [7:0] rd_data_reg;

    leb_pkg::leb_key_t key_reg;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] len_reg, len_next;
    logic          ins_reg, ins_next;
    logic          done_reg, done_next;
    logic          redraw_reg, redraw_next;
    logic          put_en_reg, put_en_next;
    logic [PW-1:0] put_addr_reg, put_addr_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] src_reg, src_next;
    logic          dir_right_reg, dir_right_next;
    logic          pend_reg, pend_next;
    logic [PW-1:0] pend_addr_reg, pend_addr_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    leb_pkg::leb_res_t out_reg;

    logic          accept;
    logic          out_blocked;
    logic          out_load;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [7:0]    wr_data;

    assign key_stall   = (ctrl.act != leb_pkg::ACT_ACCEPT);
    assign accept      = key_valid && !key_stall;
    assign out_blocked = out_valid_reg && res_stall;
    assign out_load    = ((ctrl.act == leb_pkg::ACT_CHAR) || (ctrl.act == leb_pkg::ACT_STATUS))
                         && !out_blocked;

    assign flags.key_live    = key_valid && !done_reg;
    assign flags.shift_busy  = (cnt_reg != '0);
    assign flags.no_redraw   = !redraw_reg || (len_reg == '0);
    assign flags.more        = ({1'b0, idx_reg} + {1'b0, ONE}) < {1'b0, len_reg};
    assign flags.out_blocked = out_blocked;

    // Memory port control
    assign rd_en   = ((ctrl.act == leb_pkg::ACT_SHIFT) && (cnt_reg != '0))
                     || (ctrl.act == leb_pkg::ACT_READ);
    assign rd_addr = (ctrl.act == leb_pkg::ACT_READ) ? idx_reg : src_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = rd_data_reg;
        if (ctrl.act == leb_pkg::ACT_SHIFT)
        begin
            wr_en = pend_reg;
        end
        else if (ctrl.act == leb_pkg::ACT_PUT)
        begin
            wr_en   = put_en_reg;
            wr_addr = put_addr_reg;
            wr_data = key_reg.key_code;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Edit state
    always_comb
    begin
        cur_next       = cur_reg;
        len_next       = len_reg;
        ins_next       = ins_reg;
        done_next      = done_reg;
        redraw_next    = redraw_reg;
        put_en_next    = put_en_reg;
        put_addr_next  = put_addr_reg;
        cnt_next       = cnt_reg;
        src_next       = src_reg;
        dir_right_next = dir_right_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        idx_next       = idx_reg;
        case (ctrl.act)
            leb_pkg::ACT_DECODE:
            begin
                redraw_next   = 1'b0;
                put_en_next   = 1'b0;
                cnt_next      = '0;
                pend_next     = 1'b0;
                put_addr_next = cur_reg;
                if (key_reg.kind)
                begin
                    if (key_reg.key_code == leb_pkg::KEY_LEFT && cur_reg != '0)
                        cur_next = cur_reg - ONE;
                    else if (key_reg.key_code == leb_pkg::KEY_RIGHT && cur_reg < len_reg)
                        cur_next = cur_reg + ONE;
                    else if (key_reg.key_code == leb_pkg::KEY_INSERT)
                        ins_next = !ins_reg;
                    else if (key_reg.key_code == leb_pkg::KEY_DELETE && cur_reg < len_reg)
                    begin
                        cnt_next       = len_reg - cur_reg - ONE;
                        src_next       = cur_reg + ONE;
                        dir_right_next = 1'b0;
                        len_next       = len_reg - ONE;
                        redraw_next    = 1'b1;
                    end
                end
                else
                begin
                    if (key_reg.key_code == leb_pkg::KEY_ESCAPE)
                        done_next = 1'b1;
                    if (key_reg.key_code == leb_pkg::KEY_BACKSPACE && cur_reg != '0)
                    begin
                        cnt_next       = len_reg - cur_reg;
                        src_next       = cur_reg;
                        dir_right_next = 1'b0;
                        cur_next       = cur_reg - ONE;
                        len_next       = len_reg - ONE;
                        redraw_next    = 1'b1;
                    end
                    else if (key_reg.key_code inside {[leb_pkg::PRINT_LOW:leb_pkg::PRINT_HIGH]})
                    begin
                        redraw_next = 1'b1;
                        if (ins_reg)
                        begin
                            if (len_reg < LAST_POS)
                            begin
                                cnt_next       = len_reg - cur_reg;
                                src_next       = len_reg - ONE;
                                dir_right_next = 1'b1;
                                put_en_next    = 1'b1;
                                len_next       = len_reg + ONE;
                                cur_next       = cur_reg + ONE;
                            end
                        end
                        else if (cur_reg < LAST_POS)
                        begin
                            put_en_next = 1'b1;
                            cur_next    = cur_reg + ONE;
                            if (cur_reg >= len_reg)
                                len_next = len_reg + ONE;
                        end
                    end
                end
            end
            leb_pkg::ACT_SHIFT:
            begin
                // issue one read, write back the word read last cycle
                if (cnt_reg != '0)
                begin
                    cnt_next       = cnt_reg - ONE;
                    pend_next      = 1'b1;
                    src_next       = dir_right_reg ? (src_reg - ONE) : (src_reg + ONE);
                    pend_addr_next = dir_right_reg ? (src_reg + ONE) : (src_reg - ONE);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            leb_pkg::ACT_PUT:
            begin
                idx_next = '0;
            end
            leb_pkg::ACT_CHAR:
            begin
                if (!out_blocked)
                    idx_next = idx_reg + ONE;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            len_reg       <= '0;
            ins_reg       <= 1'b1;
            done_reg      <= 1'b0;
            redraw_reg    <= 1'b0;
            put_en_reg    <= 1'b0;
            cnt_reg       <= '0;
            dir_right_reg <= 1'b0;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            len_reg       <= len_next;
            ins_reg       <= ins_next;
            done_reg      <= done_next;
            redraw_reg    <= redraw_next;
            put_en_reg    <= put_en_next;
            cnt_reg       <= cnt_next;
            dir_right_reg <= dir_right_next;
            pend_reg      <= pend_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            key_reg <= key;
        put_addr_reg  <= put_addr_next;
        src_reg       <= src_next;
        pend_addr_reg <= pend_addr_next;
    end

    // Output register
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!res_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (ctrl.act == leb_pkg::ACT_CHAR)
            begin
                out_reg.item_type  <= leb_pkg::ITEM_CHAR;
                out_reg.char_value <= rd_data_reg;
                out_reg.char_index <= 6'(idx_reg);
                out_reg.last       <= 1'b0;
            end
            else
            begin
                out_reg.item_type  <= leb_pkg::ITEM_STATUS;
                out_reg.char_value <= 8'd0;
                out_reg.char_index <= 6'd0;
                out_reg.last       <= 1'b1;
            end
            out_reg.cursor      <= 6'(cur_reg);
            out_reg.line_length <= 6'(len_reg);
            out_reg.insert_on   <= ins_reg;
            out_reg.finished    <= done_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ===== rtl/core/line_edit_buffer.sv =====
// Line edit buffer: one-line text editor driven by key words, microcoded control.
// A key is decoded, any tail shift moves one character per cycle (separate read and write
// ports on the line store), the new character is written, and the line is redrawn, each
// character read then emitted, held while the output stalls. Keys with no redraw go to the
// status word; keys after finished are taken with no output. Reset (async, rst_n low)
// clears cursor, length, finished, and sets insert mode; the line store is not cleared.
`timescale 1ns / 1ps

module line_edit_buffer
#(
    parameter int LINE_CAPACITY = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              key_valid,
    output logic              key_stall,
    input  leb_pkg::leb_key_t key,
    output logic              res_valid,
    input  logic              res_stall,
    output leb_pkg::leb_res_t res
);

    // Control word from the program table; flags back from the datapath.
    leb_pkg::leb_ctrl_t  ctrl;
    leb_pkg::leb_flags_t flags;

    // Step counter walks the program: wait for a key word, decode it,
    // shift the tail, write the new character, then redraw when needed
    // and close with the status word.
    leb_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Line store, edit registers and the output register. The output
    // register lets the next key word in while the status word waits.
    leb_datapath
    #(
        .LINE_CAPACITY (LINE_CAPACITY)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .flags     (flags),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .key       (key),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// ===== rtl/core/leb_checker.sv =====
// leb_checker: port-level checks on the line edit buffer, attached by bind.
// Depends on leb_pkg and the line_edit_buffer port list.
`timescale 1ns / 1ps

module leb_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              key_valid,
    input logic              key_stall,
    input leb_pkg::leb_key_t key,
    input logic              res_valid,
    input logic              res_stall,
    input leb_pkg::leb_res_t res
);

    // Hold a stalled input word.
    a_key_hold: assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_stall |=> key_valid && $stable(key))
        else $error("input word changed while stalled");

    // Hold a stalled output word.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("output word changed while stalled");

    // Status word closes a key and carries no character.
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.item_type |-> res.last && res.char_value == 8'd0
                                       && res.char_index == 6'd0)
        else $error("malformed status word");

    // Character words sit inside the line and never close a key.
    a_char_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.item_type |-> !res.last && res.char_index < res.line_length)
        else $error("malformed character word");

    // Once finished is delivered, nothing follows.
    a_finished_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && res.finished |=> !res_valid)
        else $error("output after finished");

endmodule

bind line_edit_buffer leb_checker u_leb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key       (key),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
